FILE: rtl/core/nscf_pkg.sv
// ----------------------------------------------------------------------------
// nscf_pkg
// Shared types, character codes and helpers for the NMEA sentence checksum
// framer.
// ----------------------------------------------------------------------------
package nscf_pkg;

    // Body size limit; one count value is held back, so CAPACITY-1 bytes are passed on.
    localparam int BODY_CAPACITY = 128;
    localparam int CNT_W         = $clog2(BODY_CAPACITY);
    localparam int POS_W         = 7;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] HEX_TEN  = 8'd10;
    localparam int         HEX_SH   = 4;

    localparam logic [CNT_W-1:0] BODY_LIMIT = CNT_W'(BODY_CAPACITY - 1);

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_BODY = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef logic [CNT_W-1:0] t_body_cnt;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        payload_byte;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  body_length;
    } t_result;

    // Byte count reported modulo 128.
    function automatic logic [POS_W-1:0] to_pos(input t_body_cnt cnt);
        logic [CNT_W+POS_W-1:0] w;
        w = {{POS_W{1'b0}}, cnt};
        return w[POS_W-1:0];
    endfunction

    // Uppercase hex decode, no validity check; 0x80 and up take the digit path.
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CH_A && !c[7]) begin
            d = c - CH_A + HEX_TEN;
        end else begin
            d = c - CH_ZERO;
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/nmea_sentence_checksum_framer_top.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer_top
// Path: a byte is accepted into the input register, decoded combinationally
// and its result is held in the result register until it is taken.
// Throughput: one byte per cycle; the result register frees in the cycle
// it is taken, so the input keeps running under a steady master ready.
// Reset: synchronous active low; clears both valid flags and returns the
// parser to waiting for start with XOR, checksum and count at zero.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] payload_byte, [14:8] position,
                                     // [21:15] body_length, [23:22] zero
    output logic [1:0]  o_m_tuser    // [1:0] kind
);

    logic              w_in_valid;
    logic [7:0]        w_in_byte;
    logic              w_out_free;
    logic              w_take;
    logic              w_res_valid;
    nscf_pkg::t_result w_res;

    assign w_take = w_in_valid && w_out_free;

    nscf_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_take     (w_take),
        .o_valid    (w_in_valid),
        .o_byte     (w_in_byte)
    );

    nscf_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    nscf_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_take),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

FILE: rtl/core/nscf_in_stage.sv
// ----------------------------------------------------------------------------
// nscf_in_stage
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module nscf_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_s_tready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_byte <= i_s_tdata;
        end
    end

endmodule

FILE: rtl/core/nscf_parse.sv
// ----------------------------------------------------------------------------
// nscf_parse
// Sentence state, running XOR and checksum decode; one byte per request.
// ----------------------------------------------------------------------------
module nscf_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output nscf_pkg::t_result o_res
);

    nscf_pkg::t_phase    r_phase, n_phase;
    logic [7:0]          r_xor, n_xor;
    logic [7:0]          r_sum, n_sum;
    nscf_pkg::t_body_cnt r_cnt, n_cnt;

    logic [7:0] w_sum_next;

    assign w_sum_next = {r_sum[7-nscf_pkg::HEX_SH:0], {nscf_pkg::HEX_SH{1'b0}}}
                        + nscf_pkg::hex_digit(i_byte);

    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        o_res_valid = 1'b0;
        o_res       = '{kind: nscf_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
                        position: '0, body_length: '0};
        if (i_byte == nscf_pkg::CH_START) begin
            // start mark wins in every phase
            n_phase = nscf_pkg::PH_BODY;
            n_xor   = 8'd0;
            n_sum   = 8'd0;
            n_cnt   = '0;
        end else begin
            unique case (r_phase)
                nscf_pkg::PH_BODY: begin
                    if (i_byte == nscf_pkg::CH_STAR) begin
                        n_phase = nscf_pkg::PH_HEX1;
                    end else begin
                        n_xor = r_xor ^ i_byte;
                        if (r_cnt < nscf_pkg::BODY_LIMIT) begin
                            o_res_valid        = 1'b1;
                            o_res.payload_byte = i_byte;
                            o_res.position     = nscf_pkg::to_pos(r_cnt);
                            n_cnt              = r_cnt + nscf_pkg::t_body_cnt'(1);
                        end
                    end
                end
                nscf_pkg::PH_HEX1: begin
                    n_sum   = w_sum_next;
                    n_phase = nscf_pkg::PH_HEX2;
                end
                nscf_pkg::PH_HEX2: begin
                    n_sum             = w_sum_next;
                    n_phase           = nscf_pkg::PH_WAIT;
                    o_res_valid       = 1'b1;
                    o_res.body_length = nscf_pkg::to_pos(r_cnt);
                    if (r_xor == w_sum_next) begin
                        o_res.kind = nscf_pkg::KIND_GOOD;
                        n_cnt      = '0;
                    end else begin
                        o_res.kind = nscf_pkg::KIND_ERROR;
                    end
                    n_xor = r_xor ^ w_sum_next;
                end
                default: begin
                    // waiting: everything but the start mark is dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nscf_pkg::PH_WAIT;
            r_xor   <= 8'd0;
            r_sum   <= 8'd0;
            r_cnt   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/nscf_out_stage.sv
// ----------------------------------------------------------------------------
// nscf_out_stage
// Result register toward the master side; reloads in the cycle it is taken.
// ----------------------------------------------------------------------------
module nscf_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  nscf_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata,  // [7:0] payload_byte, [14:8] position,
                                          // [21:15] body_length, [23:22] zero
    output logic [1:0]        o_m_tuser   // [1:0] kind
);

    logic              r_valid;
    nscf_pkg::t_result r_res;

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_res.body_length, r_res.position, r_res.payload_byte};
    assign o_m_tuser  = r_res.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/core/nscf_checker.sv
// ----------------------------------------------------------------------------
// nscf_checker
// Port-level checks on the framer's result stream and its input handshake.
// ----------------------------------------------------------------------------
module nscf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // only the three defined kinds appear
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == nscf_pkg::KIND_PAYLOAD
                        || o_m_tuser == nscf_pkg::KIND_GOOD
                        || o_m_tuser == nscf_pkg::KIND_ERROR))
        else $error("illegal result kind");

    // verdicts carry no byte and no position
    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != nscf_pkg::KIND_PAYLOAD) |-> (o_m_tdata[14:0] == 15'd0))
        else $error("verdict with payload bits set");

    // payload bytes carry no length
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == nscf_pkg::KIND_PAYLOAD) |-> (o_m_tdata[23:15] == 9'd0))
        else $error("payload with length bits set");

    // a stalled request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // a waiting input request is held by the sender
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && !o_s_tready) |=> (i_s_tvalid && $stable(i_s_tdata)))
        else $error("stalled input request changed");

endmodule

bind nmea_sentence_checksum_framer_top nscf_checker u_nscf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
